// ===== hdl/dis_pkg.sv =====
// Shared types, constants and helpers for the disjoint interval set.
// Depends on nothing; used by every other file of the block except dis_checker.
package dis_pkg;

  localparam int MaxIntervalsDef = 32;
  localparam int TimeW = 64;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic signed [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};

  // Per-item result flags and data, handed from the engine to the top level.
  typedef struct packed {
    logic             done;
    logic             contained;
    logic             rd_valid;
    logic [TimeW-1:0] rd_start;
    logic [TimeW-1:0] rd_end;
    logic             overflow;
    logic             abnormal;
    logic [TimeW-1:0] first;
    logic [TimeW-1:0] last;
  } result_t;

  // An interval ending at e overlaps or abuts one that starts at s.
  function automatic logic touches(logic signed [TimeW-1:0] e,
                                   logic signed [TimeW-1:0] s);
    return (s == TimeMin) || (e >= s - 64'sd1);
  endfunction

  function automatic logic signed [TimeW-1:0] smax(logic signed [TimeW-1:0] a,
                                                   logic signed [TimeW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/disjoint_interval_set_top.sv =====
// Top level of the disjoint interval set: command handshake and result formatting.
// Depends on dis_pkg and dis_engine.
//
// The block keeps a sorted table of disjoint, non-adjacent, inclusive signed 64-bit
// intervals in a two-bank memory. An item is taken when start is high and busy is
// low; its result appears for exactly one cycle with result_valid_o high and must be
// captured then, as the receiver cannot stall it. Add and remove stream the n stored
// entries, one per cycle except in the step in which an add takes in its new
// interval or a remove writes the second piece of a split entry, from the live
// bank into the spare bank, and swap banks on success. A query reads the stored
// entries through the single memory read port in the same way. Clear, read,
// ignored and unused-opcode items go straight to the finishing step; the result
// is shown in the cycle in which busy falls, and a new item may be taken in that
// same cycle. An item that would need more than MaxIntervals entries leaves the
// table untouched and reports overflow; an add or remove with start above end is
// ignored and flagged. No clearing pass is needed after reset.
module disjoint_interval_set_top #(
  parameter int MaxIntervals = dis_pkg::MaxIntervalsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                opcode_i,
  input  logic [dis_pkg::TimeW-1:0] range_start_i,
  input  logic [dis_pkg::TimeW-1:0] range_end_i,
  input  logic [dis_pkg::TimeW-1:0] query_time_i,
  input  logic [4:0]                entry_index_i,
  output logic                      result_valid_o,
  output logic                      is_contained_o,
  output logic [dis_pkg::TimeW-1:0] earliest_time_o,
  output logic [dis_pkg::TimeW-1:0] latest_time_o,
  output logic [5:0]                interval_count_o,
  output logic                      is_empty_o,
  output logic                      is_continuous_o,
  output logic [dis_pkg::TimeW-1:0] read_start_o,
  output logic [dis_pkg::TimeW-1:0] read_end_o,
  output logic                      read_valid_o,
  output logic                      overflow_o,
  output logic                      ignored_abnormal_o
);

  localparam int CW = $clog2(MaxIntervals + 2);

  logic             accept;
  logic [CW-1:0]    count;
  dis_pkg::result_t res;

  // An item enters only while the engine is idle.
  assign accept = start && !busy;

  dis_engine #(.MaxIntervals(MaxIntervals), .CW(CW)) u_engine (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(accept), .opcode_i(opcode_i),
    .range_start_i(range_start_i), .range_end_i(range_end_i),
    .query_time_i(query_time_i), .entry_index_i(entry_index_i),
    .busy_o(busy), .count_o(count), .res_o(res)
  );

  // The summary fields describe the committed table; the first and last entries
  // read as zero whenever the table is empty.
  assign result_valid_o     = res.done;
  assign is_contained_o     = res.contained;
  assign earliest_time_o    = (count != '0) ? res.first : '0;
  assign latest_time_o      = (count != '0) ? res.last : '0;
  assign interval_count_o   = 6'(count);
  assign is_empty_o         = count == '0;
  assign is_continuous_o    = count <= CW'(1);
  assign read_start_o       = res.rd_start;
  assign read_end_o         = res.rd_end;
  assign read_valid_o       = res.rd_valid;
  assign overflow_o         = res.overflow;
  assign ignored_abnormal_o = res.abnormal;

endmodule

// ===== hdl/dis_mem.sv =====
// Two-bank interval store: one write port, one registered read port.
// Depends on dis_pkg for the time width.
module dis_mem #(
  parameter int AW = 6
) (
  input  logic                      clk_i,
  input  logic [AW-1:0]             raddr_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [dis_pkg::TimeW-1:0] wstart_i,
  input  logic [dis_pkg::TimeW-1:0] wend_i,
  output logic [dis_pkg::TimeW-1:0] rstart_o,
  output logic [dis_pkg::TimeW-1:0] rend_o
);

  logic [2*dis_pkg::TimeW-1:0] mem_q [2**AW];
  logic [2*dis_pkg::TimeW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wstart_i, wend_i};
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rstart_o = rdata_q[2*dis_pkg::TimeW-1:dis_pkg::TimeW];
  assign rend_o   = rdata_q[dis_pkg::TimeW-1:0];

endmodule

// ===== hdl/dis_engine.sv =====
// Sequencer that streams the table from one memory bank into the other, merging
// or cutting intervals and committing by a bank swap; it also scans, reads and clears.
// Depends on dis_pkg and dis_mem.
module dis_engine #(
  parameter int MaxIntervals = dis_pkg::MaxIntervalsDef,
  parameter int CW = $clog2(MaxIntervals + 2)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_i,
  input  logic [2:0]                opcode_i,
  input  logic [dis_pkg::TimeW-1:0] range_start_i,
  input  logic [dis_pkg::TimeW-1:0] range_end_i,
  input  logic [dis_pkg::TimeW-1:0] query_time_i,
  input  logic [4:0]                entry_index_i,
  output logic                      busy_o,
  output logic [CW-1:0]             count_o,
  output dis_pkg::result_t          res_o
);

  localparam int IW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int XW = (CW > 5) ? CW : 5;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic signed [63:0] s_q, s_d, e_q, e_d, t_q, t_d;
  logic [4:0] idx_q, idx_d;
  logic sel_q, sel_d;
  logic [CW-1:0] cnt_q, cnt_d, ri_q, ri_d, wcnt_q, wcnt_d;
  logic nused_q, nused_d, acc_v_q, acc_v_d, pend_v_q, pend_v_d, hit_q, hit_d;
  logic signed [63:0] acc_s_q, acc_s_d, acc_e_q, acc_e_d;
  logic signed [63:0] pend_s_q, pend_s_d, pend_e_q, pend_e_d;
  logic signed [63:0] nf_q, nf_d, nl_q, nl_d, first_q, first_d, last_q, last_d;
  dis_pkg::result_t res_q, res_d;

  logic [IW:0] raddr, waddr;
  logic we;
  logic [63:0] rd_s, rd_e;
  logic signed [63:0] os, oe, xs, xe, emit_s, emit_e;
  logic emit_v, take_x, old_avail, is_upd, abn;

  dis_mem #(.AW(IW + 1)) u_mem (
    .clk_i(clk_i), .raddr_i(raddr), .we_i(we), .waddr_i(waddr),
    .wstart_i(emit_s), .wend_i(emit_e), .rstart_o(rd_s), .rend_o(rd_e)
  );

  always_comb begin
    state_d = state_q; op_d = op_q; s_d = s_q; e_d = e_q; t_d = t_q; idx_d = idx_q;
    sel_d = sel_q; cnt_d = cnt_q; ri_d = ri_q; wcnt_d = wcnt_q; nused_d = nused_q;
    acc_v_d = acc_v_q; acc_s_d = acc_s_q; acc_e_d = acc_e_q;
    pend_v_d = pend_v_q; pend_s_d = pend_s_q; pend_e_d = pend_e_q;
    nf_d = nf_q; nl_d = nl_q; first_d = first_q; last_d = last_q; hit_d = hit_q;
    res_d = res_q; res_d.done = 1'b0;
    emit_v = 1'b0; emit_s = acc_s_q; emit_e = acc_e_q;
    take_x = 1'b0; xs = s_q; xe = e_q;
    os = $signed(rd_s); oe = $signed(rd_e);
    old_avail = ri_q < cnt_q;
    is_upd = (op_q == dis_pkg::OP_ADD) || (op_q == dis_pkg::OP_REMOVE);
    abn = s_q > e_q;
    raddr = {sel_q, ri_q[IW-1:0]};
    case (state_q)
      S_IDLE: begin
        if (cmd_i) begin
          op_d = opcode_i; s_d = $signed(range_start_i); e_d = $signed(range_end_i);
          t_d = $signed(query_time_i); idx_d = entry_index_i;
          ri_d = '0; wcnt_d = '0; nused_d = 1'b0; acc_v_d = 1'b0;
          pend_v_d = 1'b0; hit_d = 1'b0;
          raddr = {sel_q, {IW{1'b0}}};
          state_d = S_FIN;
          if (opcode_i == dis_pkg::OP_READ) begin
            raddr = {sel_q, IW'(entry_index_i)};
          end
          if (opcode_i == dis_pkg::OP_CLEAR) begin
            cnt_d = '0;
          end
          if (opcode_i == dis_pkg::OP_QUERY) begin
            state_d = S_SCAN;
          end
          if ((opcode_i == dis_pkg::OP_ADD || opcode_i == dis_pkg::OP_REMOVE) &&
              !($signed(range_start_i) > $signed(range_end_i))) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (op_q == dis_pkg::OP_ADD) begin
          if (old_avail && (nused_q || !(s_q < os))) begin
            take_x = 1'b1; xs = os; xe = oe; ri_d = ri_q + 1'b1;
          end else if (!nused_q) begin
            take_x = 1'b1; nused_d = 1'b1;
          end else begin
            emit_v = acc_v_q; state_d = S_FIN;
          end
          if (take_x) begin
            if (!acc_v_q) begin
              acc_v_d = 1'b1; acc_s_d = xs; acc_e_d = xe;
            end else if (dis_pkg::touches(acc_e_q, xs)) begin
              acc_e_d = dis_pkg::smax(acc_e_q, xe);
            end else begin
              emit_v = 1'b1; acc_s_d = xs; acc_e_d = xe;
            end
          end
        end else if (op_q == dis_pkg::OP_REMOVE) begin
          if (pend_v_q) begin
            emit_v = 1'b1; emit_s = pend_s_q; emit_e = pend_e_q; pend_v_d = 1'b0;
          end else if (old_avail) begin
            ri_d = ri_q + 1'b1;
            if (oe < s_q || e_q < os) begin
              emit_v = 1'b1; emit_s = os; emit_e = oe;
            end else if (os < s_q) begin
              emit_v = 1'b1; emit_s = os; emit_e = s_q - 64'sd1;
              if (e_q < oe) begin
                pend_v_d = 1'b1; pend_s_d = e_q + 64'sd1; pend_e_d = oe;
              end
            end else if (e_q < oe) begin
              emit_v = 1'b1; emit_s = e_q + 64'sd1; emit_e = oe;
            end
          end else begin
            state_d = S_FIN;
          end
        end else begin
          if (old_avail) begin
            ri_d = ri_q + 1'b1;
            if (os <= t_q && t_q <= oe) begin
              hit_d = 1'b1;
            end
          end else begin
            state_d = S_FIN;
          end
        end
        raddr = {sel_q, ri_d[IW-1:0]};
        if (emit_v) begin
          wcnt_d = wcnt_q + 1'b1;
          nl_d = emit_e;
          if (wcnt_q == '0) begin
            nf_d = emit_s;
          end
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        res_d.done = 1'b1;
        res_d.contained = (op_q == dis_pkg::OP_QUERY) && hit_q;
        res_d.rd_valid = (op_q == dis_pkg::OP_READ) && (XW'(idx_q) < XW'(cnt_q));
        res_d.rd_start = res_d.rd_valid ? rd_s : '0;
        res_d.rd_end = res_d.rd_valid ? rd_e : '0;
        res_d.abnormal = is_upd && abn;
        res_d.overflow = is_upd && !abn && (wcnt_q > CW'(MaxIntervals));
        if (is_upd && !abn && !res_d.overflow) begin
          sel_d = ~sel_q; cnt_d = wcnt_q; first_d = nf_q; last_d = nl_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    we = emit_v && (wcnt_q < CW'(MaxIntervals));
    waddr = {~sel_q, wcnt_q[IW-1:0]};
    res_d.first = first_d;
    res_d.last = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q <= 1'b0;
      cnt_q <= '0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; s_q <= s_d; e_q <= e_d; t_q <= t_d; idx_q <= idx_d;
    ri_q <= ri_d; wcnt_q <= wcnt_d; nused_q <= nused_d; hit_q <= hit_d;
    acc_v_q <= acc_v_d; acc_s_q <= acc_s_d; acc_e_q <= acc_e_d;
    pend_v_q <= pend_v_d; pend_s_q <= pend_s_d; pend_e_q <= pend_e_d;
    nf_q <= nf_d; nl_q <= nl_d; first_q <= first_d; last_q <= last_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign count_o = cnt_q;
  assign res_o = res_q;

endmodule

// ===== hdl/dis_checker.sv =====
// Port-level checks of the disjoint interval set, bound to the top level.
// Depends on disjoint_interval_set_top.
module dis_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       overflow_o,
  input logic       ignored_abnormal_o,
  input logic       read_valid_o,
  input logic [5:0] interval_count_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item accepted without going busy");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) && !busy) else $error("result without work");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(overflow_o && ignored_abnormal_o))
    else $error("overflow and abnormal together");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && read_valid_o |-> interval_count_o != 6'd0 || $past(busy, 2))
    else $error("valid read from an empty table");

endmodule

bind disjoint_interval_set_top dis_checker u_dis_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .result_valid_o(result_valid_o), .overflow_o(overflow_o),
  .ignored_abnormal_o(ignored_abnormal_o), .read_valid_o(read_valid_o),
  .interval_count_o(interval_count_o)
);

// ===== tb/disjoint_interval_set_top_test.sv =====
// Self-checking testbench for the disjoint interval set top level.
// Depends on dis_pkg and disjoint_interval_set_top.
module disjoint_interval_set_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 32;
  localparam int RandomItems = 1200;
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast = 3'd7;
  localparam longint TimeLo = 64'sh8000_0000_0000_0000;
  localparam longint TimeHi = 64'sh7fff_ffff_ffff_ffff;

  // One result as the block reports it.
  typedef struct packed {
    logic         contained;
    logic [63:0]  first;
    logic [63:0]  last;
    logic [5:0]   count;
    logic         empty;
    logic         continuous;
    logic [63:0]  rd_start;
    logic [63:0]  rd_end;
    logic         rd_valid;
    logic         overflow;
    logic         abnormal;
  } summary_t;

  // Holds its own copy of the interval table, works out the summary that
  // each accepted item must produce and checks the results in order.
  class interval_scoreboard;
    longint   tbl_s[TableDepth];
    longint   tbl_e[TableDepth];
    int       cnt;
    longint   wk_s[TableDepth+1];
    longint   wk_e[TableDepth+1];
    int       wn;
    summary_t pending[$];
    int       errors;

    function new();
      cnt = 0;
      errors = 0;
    endfunction

    // An interval ending at e overlaps or abuts one starting at s; the
    // lowest start abuts anything, which also keeps s - 1 from wrapping.
    function bit abuts(longint e, longint s);
      if (s == TimeLo) return 1;
      return e >= s - 1;
    endfunction

    function void wk_drop(int i);
      for (int k = i; k + 1 < wn; k++) begin
        wk_s[k] = wk_s[k+1];
        wk_e[k] = wk_e[k+1];
      end
      wn--;
    endfunction

    function void wk_put(int i, longint s, longint e);
      for (int k = wn; k > i; k--) begin
        wk_s[k] = wk_s[k-1];
        wk_e[k] = wk_e[k-1];
      end
      wk_s[i] = s;
      wk_e[i] = e;
      wn++;
    endfunction

    function void merge_in(longint s, longint e);
      int pos;
      int at;
      pos = 0;
      while (pos < wn && !(s < wk_s[pos])) pos++;
      wk_put(pos, s, e);
      at = pos;
      if (pos > 0 && abuts(wk_e[pos-1], s)) at = pos - 1;
      while (at + 1 < wn) begin
        if (!abuts(wk_e[at], wk_s[at+1])) break;
        if (wk_e[at+1] > wk_e[at]) wk_e[at] = wk_e[at+1];
        wk_drop(at + 1);
      end
    endfunction

    function void cut_out(longint s, longint e);
      int     i;
      longint rs;
      longint re;
      i = 0;
      while (i < wn) begin
        rs = wk_s[i];
        re = wk_e[i];
        if (re < s) begin
          i++;
        end else if (e < rs) begin
          break;
        end else if (rs < s && e < re) begin
          wk_e[i] = s - 1;
          wk_put(i + 1, e + 1, re);
          break;
        end else if (rs < s) begin
          wk_e[i] = s - 1;
          i++;
        end else if (e < re) begin
          wk_s[i] = e + 1;
          break;
        end else begin
          wk_drop(i);
        end
      end
    endfunction

    function void note(logic [2:0] op, longint s, longint e, longint t, logic [4:0] idx);
      summary_t x;
      x = '0;
      if (op == dis_pkg::OP_ADD || op == dis_pkg::OP_REMOVE) begin
        if (s > e) begin
          x.abnormal = 1'b1;
        end else begin
          wn = cnt;
          for (int k = 0; k < TableDepth; k++) begin
            wk_s[k] = tbl_s[k];
            wk_e[k] = tbl_e[k];
          end
          if (op == dis_pkg::OP_ADD) merge_in(s, e);
          else cut_out(s, e);
          if (wn > TableDepth) begin
            x.overflow = 1'b1;
          end else begin
            for (int k = 0; k < TableDepth; k++) begin
              tbl_s[k] = wk_s[k];
              tbl_e[k] = wk_e[k];
            end
            cnt = wn;
          end
        end
      end else if (op == dis_pkg::OP_CLEAR) begin
        cnt = 0;
      end else if (op == dis_pkg::OP_QUERY) begin
        for (int k = 0; k < cnt; k++) begin
          if (tbl_s[k] <= t && t <= tbl_e[k]) begin
            x.contained = 1'b1;
            break;
          end
          if (t < tbl_s[k]) break;
        end
      end else if (op == dis_pkg::OP_READ) begin
        if (idx < cnt) begin
          x.rd_valid = 1'b1;
          x.rd_start = tbl_s[idx];
          x.rd_end = tbl_e[idx];
        end
      end
      x.first = cnt ? tbl_s[0] : 64'd0;
      x.last = cnt ? tbl_e[cnt-1] : 64'd0;
      x.count = cnt[5:0];
      x.empty = (cnt == 0);
      x.continuous = (cnt <= 1);
      pending = {pending, x};
    endfunction

    function void check(summary_t got);
      summary_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing outstanding: %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.contained != want.contained)
        $display("%0t: is_contained expected %0d got %0d", $realtime, want.contained,
                 got.contained);
      if (got.first != want.first)
        $display("%0t: earliest_time expected %0d got %0d", $realtime,
                 $signed(want.first), $signed(got.first));
      if (got.last != want.last)
        $display("%0t: latest_time expected %0d got %0d", $realtime,
                 $signed(want.last), $signed(got.last));
      if (got.count != want.count)
        $display("%0t: interval_count expected %0d got %0d", $realtime, want.count,
                 got.count);
      if (got.empty != want.empty)
        $display("%0t: is_empty expected %0d got %0d", $realtime, want.empty, got.empty);
      if (got.continuous != want.continuous)
        $display("%0t: is_continuous expected %0d got %0d", $realtime, want.continuous,
                 got.continuous);
      if (got.rd_start != want.rd_start)
        $display("%0t: read_start expected %0d got %0d", $realtime,
                 $signed(want.rd_start), $signed(got.rd_start));
      if (got.rd_end != want.rd_end)
        $display("%0t: read_end expected %0d got %0d", $realtime,
                 $signed(want.rd_end), $signed(got.rd_end));
      if (got.rd_valid != want.rd_valid)
        $display("%0t: read_valid expected %0d got %0d", $realtime, want.rd_valid,
                 got.rd_valid);
      if (got.overflow != want.overflow)
        $display("%0t: overflow expected %0d got %0d", $realtime, want.overflow,
                 got.overflow);
      if (got.abnormal != want.abnormal)
        $display("%0t: ignored_abnormal expected %0d got %0d", $realtime, want.abnormal,
                 got.abnormal);
      if (got != want) errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode_i = dis_pkg::OP_CLEAR;
  logic [63:0] range_start_i = '0;
  logic [63:0] range_end_i = '0;
  logic [63:0] query_time_i = '0;
  logic [4:0]  entry_index_i = '0;
  logic        result_valid_o;
  summary_t    seen;

  interval_scoreboard table_model = new();

  disjoint_interval_set_top dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .range_start_i, .range_end_i,
    .query_time_i, .entry_index_i, .result_valid_o,
    .is_contained_o(seen.contained),
    .earliest_time_o(seen.first),
    .latest_time_o(seen.last),
    .interval_count_o(seen.count),
    .is_empty_o(seen.empty),
    .is_continuous_o(seen.continuous),
    .read_start_o(seen.rd_start),
    .read_end_o(seen.rd_end),
    .read_valid_o(seen.rd_valid),
    .overflow_o(seen.overflow),
    .ignored_abnormal_o(seen.abnormal)
  );

  always #4 clk_i = ~clk_i;

  // Sampled at the rising edge, before any of this edge's updates land. A
  // result always belongs to an item taken earlier, so it is checked before
  // an item taken at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) table_model.check(seen);
      if (start && !busy)
        table_model.note(opcode_i, range_start_i, range_end_i, query_time_i, entry_index_i);
    end
  end

  // Burst state of the sender: items left in the current burst.
  int burst_left = 0;

  // Presents one item and returns at the edge that takes it. Between bursts
  // the start line drops for a random gap unless that gap is zero; within a burst the
  // next item follows straight on, so start is never lowered and raised in
  // one step.
  task automatic issue(logic [2:0] op, longint s, longint e, longint t, logic [4:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    opcode_i <= op;
    range_start_i <= s;
    range_end_i <= e;
    query_time_i <= t;
    entry_index_i <= idx;
    do @(posedge clk_i); while (busy);
  endtask

  // Mostly small clustered times so that entries merge, split and fill the
  // table; now and then the extremes and fully random 64-bit values.
  function automatic longint pick_time();
    case ($urandom_range(0, 9))
      7: return TimeLo + $urandom_range(0, 4);
      8: return TimeHi - $urandom_range(0, 4);
      9: return {$urandom, $urandom};
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  task automatic random_item();
    int          sel;
    longint      s;
    longint      e;
    logic [2:0]  op;
    sel = $urandom_range(0, 99);
    s = pick_time();
    if ($urandom_range(0, 9) == 0) begin
      e = pick_time();
    end else if (s > TimeHi - 32) begin
      e = TimeHi;
    end else begin
      e = s + $urandom_range(0, sel < 45 ? 3 : 20);
    end
    if (sel < 45) op = dis_pkg::OP_ADD;
    else if (sel < 68) op = dis_pkg::OP_REMOVE;
    else if (sel < 82) op = dis_pkg::OP_QUERY;
    else if (sel < 95) op = dis_pkg::OP_READ;
    else if (sel < 97) op = dis_pkg::OP_CLEAR;
    else op = 3'($urandom_range(OpSpareFirst, OpSpareLast));
    issue(op, s, e, pick_time(), 5'($urandom_range(0, 31)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: query, read, and each unused opcode.
    issue(dis_pkg::OP_QUERY, 0, 0, 0, 0);
    issue(dis_pkg::OP_READ, 0, 0, 0, 0);
    for (int k = OpSpareFirst; k <= OpSpareLast; k++) issue(3'(k), 5, 9, 5, 0);
    // Intervals at the extremes of time, and their merge through adjacency.
    issue(dis_pkg::OP_ADD, TimeLo, TimeLo, 0, 0);
    issue(dis_pkg::OP_ADD, TimeHi, TimeHi, 0, 0);
    issue(dis_pkg::OP_QUERY, 0, 0, TimeHi, 0);
    issue(dis_pkg::OP_ADD, TimeLo + 1, TimeHi - 1, 0, 0);
    issue(dis_pkg::OP_READ, 0, 0, 0, 0);
    // Start above end is ignored for both add and remove.
    issue(dis_pkg::OP_ADD, 10, -10, 0, 0);
    issue(dis_pkg::OP_REMOVE, TimeHi, TimeLo, 0, 0);
    // Split the full range, trim both ends, read past the count.
    issue(dis_pkg::OP_REMOVE, -5, 5, 0, 0);
    issue(dis_pkg::OP_REMOVE, TimeLo, TimeLo, 0, 0);
    issue(dis_pkg::OP_REMOVE, TimeHi, TimeHi, 0, 0);
    issue(dis_pkg::OP_READ, 0, 0, 0, 1);
    issue(dis_pkg::OP_READ, 0, 0, 0, 31);
    issue(dis_pkg::OP_CLEAR, 0, 0, 0, 0);
    // Fill the table, then an add that needs a new entry and a remove that
    // must split one are both refused for capacity.
    for (int k = 0; k < TableDepth; k++) issue(dis_pkg::OP_ADD, 4 * k, 4 * k + 2, 0, 0);
    issue(dis_pkg::OP_ADD, 1000, 1000, 0, 0);
    issue(dis_pkg::OP_REMOVE, 1, 1, 0, 0);
    issue(dis_pkg::OP_READ, 0, 0, 0, 31);
    issue(dis_pkg::OP_CLEAR, 0, 0, 0, 0);

    for (int n = 0; n < RandomItems; n++) random_item();
    start <= 1'b0;

    while (table_model.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (table_model.errors == 0 && table_model.pending.size() == 0) begin
      $display("[disjoint_interval_set_top] OK");
    end else begin
      $display("[disjoint_interval_set_top] ERROR");
    end
    $finish;
  end

  // Generous bound on the whole run, items and gaps included.
  initial begin
    #5ms;
    $display("[disjoint_interval_set_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dis_pkg.sv
hdl/dis_mem.sv
hdl/dis_engine.sv
hdl/disjoint_interval_set_top.sv
hdl/dis_checker.sv
tb/disjoint_interval_set_top_test.sv
